// File: design/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked in every cycle, including reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

// checked only outside reset
`define ASSERT_RUN(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// File: design/rvalu_pkg.sv
// ----------------------------------------------------------------------------
// rvalu_pkg
// shared types and constants of the rv32im register alu
// ----------------------------------------------------------------------------
`default_nettype none

package rvalu_pkg;

   localparam int unsigned XLEN = 32;

   localparam logic [6:0] F7_BASE   = 7'b0000000;
   localparam logic [6:0] F7_ALT    = 7'b0100000;
   localparam logic [6:0] F7_MULDIV = 7'b0000001;

   typedef enum logic [4:0] {
      OP_ADD, OP_SUB, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_SRA, OP_OR, OP_AND,
      OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU, OP_DIV, OP_DIVU, OP_REM, OP_REMU, OP_BAD
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [XLEN-1:0]   a;
      logic [XLEN-1:0]   b;
   } uop_type;

   typedef struct packed {
      logic [1:0] count;
   } front_status_type;

   typedef struct packed {
      logic div_active;
      logic pop_plain;
   } back_status_type;

endpackage

`default_nettype wire

// File: design/rvalu_if.sv
// ----------------------------------------------------------------------------
// rvalu channel interfaces
// valid/ready channels for operation requests and results
// ----------------------------------------------------------------------------
`default_nettype none

interface rvalu_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  command;
   logic [6:0]  variant;
   logic [31:0] operand_a;
   logic [31:0] operand_b;
   modport source (output valid, command, variant, operand_a, operand_b, input ready);
   modport sink   (input valid, command, variant, operand_a, operand_b, output ready);
endinterface

interface rvalu_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result;
   logic        recognised;
   modport source (output valid, result, recognised, input ready);
   modport sink   (input valid, result, recognised, output ready);
endinterface

`default_nettype wire

// File: design/rvalu_front.sv
// ----------------------------------------------------------------------------
// rvalu_front
// decodes funct3/funct7 and holds decoded operations in a two-entry queue
// ----------------------------------------------------------------------------
`default_nettype none

module rvalu_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   rvalu_req_if.sink                       req,
   input  wire logic                       pop,
   output logic                            head_vld,
   output rvalu_pkg::uop_type              head,
   output rvalu_pkg::front_status_type     status
);
   import rvalu_pkg::*;

   function automatic op_type decode(input logic [2:0] f3, input logic [6:0] f7);
      op_type op;
      op = OP_BAD;
      if (f7 == F7_MULDIV) begin
         case (f3)
            3'd0: op = OP_MUL;
            3'd1: op = OP_MULH;
            3'd2: op = OP_MULHSU;
            3'd3: op = OP_MULHU;
            3'd4: op = OP_DIV;
            3'd5: op = OP_DIVU;
            3'd6: op = OP_REM;
            default: op = OP_REMU;
         endcase
      end else if (f7 == F7_BASE) begin
         case (f3)
            3'd0: op = OP_ADD;
            3'd1: op = OP_SLL;
            3'd2: op = OP_SLT;
            3'd3: op = OP_SLTU;
            3'd4: op = OP_XOR;
            3'd5: op = OP_SRL;
            3'd6: op = OP_OR;
            default: op = OP_AND;
         endcase
      end else if (f7 == F7_ALT && f3 == 3'd0) begin
         op = OP_SUB;
      end else if (f7 == F7_ALT && f3 == 3'd5) begin
         op = OP_SRA;
      end
      return op;
   endfunction

   uop_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   uop_type    entry;

   assign req.ready = (count_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign head_vld  = (count_ff != 2'd0);
   assign head      = mem_ff[rd_ptr_ff];
   assign status.count = count_ff;

   always_comb begin
      entry.op  = decode(req.command, req.variant);
      entry.a   = req.operand_a;
      entry.b   = req.operand_b;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: design/rvalu_div.sv
// ----------------------------------------------------------------------------
// rvalu_div
// radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rvalu_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [31:0] divisor,
   input  wire logic        is_signed,
   input  wire logic        want_rem,
   input  wire logic        take,
   output logic             active,
   output logic             done,
   output logic [31:0]      value
);
   import rvalu_pkg::*;

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [4:0]      cnt_ff, cnt_in;
   logic [XLEN-1:0] rem_ff, rem_in;
   logic [XLEN-1:0] quo_ff, quo_in;
   logic [XLEN-1:0] den_ff, den_in;
   logic            neg_q_ff, neg_q_in;
   logic            neg_r_ff, neg_r_in;
   logic            sel_rem_ff, sel_rem_in;
   logic [XLEN:0]   shifted;
   logic [XLEN+1:0] diff;

   assign active = busy_ff || done_ff;
   assign done   = done_ff;

   always_comb begin
      shifted    = {rem_ff, quo_ff[XLEN-1]};
      diff       = {1'b0, shifted} - {2'b00, den_ff};
      busy_in    = busy_ff;
      done_in    = done_ff;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      den_in     = den_ff;
      neg_q_in   = neg_q_ff;
      neg_r_in   = neg_r_ff;
      sel_rem_in = sel_rem_ff;
      if (start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         rem_in     = '0;
         quo_in     = (is_signed && dividend[XLEN-1]) ? (~dividend + 32'd1) : dividend;
         den_in     = (is_signed && divisor[XLEN-1]) ? (~divisor + 32'd1) : divisor;
         // a zero divisor keeps the all-ones quotient unsigned
         neg_q_in   = is_signed && (dividend[XLEN-1] ^ divisor[XLEN-1]) && (divisor != '0);
         neg_r_in   = is_signed && dividend[XLEN-1];
         sel_rem_in = want_rem;
      end else if (busy_ff) begin
         if (!diff[XLEN+1]) begin
            rem_in = diff[XLEN-1:0];
            quo_in = {quo_ff[XLEN-2:0], 1'b1};
         end else begin
            rem_in = shifted[XLEN-1:0];
            quo_in = {quo_ff[XLEN-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (take) begin
         done_in = 1'b0;
      end
      if (sel_rem_ff) begin
         value = neg_r_ff ? (~rem_ff + 32'd1) : rem_ff;
      end else begin
         value = neg_q_ff ? (~quo_ff + 32'd1) : quo_ff;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      den_ff     <= den_in;
      neg_q_ff   <= neg_q_in;
      neg_r_ff   <= neg_r_in;
      sel_rem_ff <= sel_rem_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

`default_nettype wire

// File: design/rvalu_back.sv
// ----------------------------------------------------------------------------
// rvalu_back
// execute stage, shared divider and result register
// ----------------------------------------------------------------------------
`default_nettype none

module rvalu_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     head_vld,
   input  rvalu_pkg::uop_type            head,
   output logic                          pop,
   rvalu_rsp_if.source                   rsp,
   output rvalu_pkg::back_status_type    status
);
   import rvalu_pkg::*;

   logic              x_vld_ff, x_vld_in;
   op_type            x_op_ff, x_op_in;
   logic [XLEN-1:0]   x_res_ff, x_res_in;
   logic [2*XLEN-1:0] x_prod_ff, x_prod_in;
   logic              out_vld_ff, out_vld_in;
   logic [XLEN-1:0]   out_res_ff, out_res_in;
   logic              out_ok_ff, out_ok_in;

   logic              is_div, is_signed_div, is_rem;
   logic              div_start, div_take, div_active, div_done;
   logic [XLEN-1:0]   div_value;
   logic              out_adv, x_free, pop_plain;
   logic [XLEN-1:0]   alu_res;
   logic [XLEN:0]     mul_a, mul_b;
   logic [2*XLEN+1:0] prod;
   logic [4:0]        sh;

   always_comb begin
      is_div        = (head.op == OP_DIV) || (head.op == OP_DIVU) ||
                      (head.op == OP_REM) || (head.op == OP_REMU);
      is_signed_div = (head.op == OP_DIV) || (head.op == OP_REM);
      is_rem        = (head.op == OP_REM) || (head.op == OP_REMU);
      out_adv       = x_vld_ff && (!out_vld_ff || rsp.ready);
      x_free        = !x_vld_ff || out_adv;
      div_start     = head_vld && is_div && !div_active;
      div_take      = div_done && x_free;
      // plain ops wait behind a divide to keep order
      pop_plain     = head_vld && !is_div && !div_active && x_free;
      pop           = div_start || pop_plain;
   end

   rvalu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (head.a),
      .divisor   (head.b),
      .is_signed (is_signed_div),
      .want_rem  (is_rem),
      .take      (div_take),
      .active    (div_active),
      .done      (div_done),
      .value     (div_value)
   );

   always_comb begin
      sh = head.b[4:0];
      case (head.op)
         OP_ADD:  alu_res = head.a + head.b;
         OP_SUB:  alu_res = head.a - head.b;
         OP_SLL:  alu_res = head.a << sh;
         OP_SLT:  alu_res = {31'd0, $signed(head.a) < $signed(head.b)};
         OP_SLTU: alu_res = {31'd0, head.a < head.b};
         OP_XOR:  alu_res = head.a ^ head.b;
         OP_SRL:  alu_res = head.a >> sh;
         OP_SRA:  alu_res = $unsigned($signed(head.a) >>> sh);
         OP_OR:   alu_res = head.a | head.b;
         OP_AND:  alu_res = head.a & head.b;
         default: alu_res = '0;
      endcase
      mul_a = {((head.op == OP_MULH) || (head.op == OP_MULHSU)) && head.a[XLEN-1], head.a};
      mul_b = {(head.op == OP_MULH) && head.b[XLEN-1], head.b};
      // full-width signed product, operands sign extended to the result width
      prod  = $signed(mul_a) * $signed(mul_b);
   end

   always_comb begin
      x_vld_in  = x_vld_ff;
      x_op_in   = x_op_ff;
      x_res_in  = x_res_ff;
      x_prod_in = x_prod_ff;
      if (div_take) begin
         x_vld_in = 1'b1;
         x_op_in  = OP_DIV;
         x_res_in = div_value;
      end else if (pop_plain) begin
         x_vld_in  = 1'b1;
         x_op_in   = head.op;
         x_res_in  = alu_res;
         x_prod_in = prod[2*XLEN-1:0];
      end else if (out_adv) begin
         x_vld_in = 1'b0;
      end

      out_vld_in = out_vld_ff;
      out_res_in = out_res_ff;
      out_ok_in  = out_ok_ff;
      if (out_adv) begin
         out_vld_in = 1'b1;
         out_ok_in  = (x_op_ff != OP_BAD);
         case (x_op_ff)
            OP_MUL:    out_res_in = x_prod_ff[XLEN-1:0];
            OP_MULH:   out_res_in = x_prod_ff[2*XLEN-1:XLEN];
            OP_MULHSU: out_res_in = x_prod_ff[2*XLEN-1:XLEN];
            OP_MULHU:  out_res_in = x_prod_ff[2*XLEN-1:XLEN];
            OP_BAD:    out_res_in = '0;
            default:   out_res_in = x_res_ff;
         endcase
      end else if (rsp.ready) begin
         out_vld_in = 1'b0;
      end
   end

   assign rsp.valid      = out_vld_ff;
   assign rsp.result     = out_res_ff;
   assign rsp.recognised = out_ok_ff;
   assign status.div_active = div_active;
   assign status.pop_plain  = pop_plain;

   always_ff @(posedge clock) begin
      x_op_ff    <= x_op_in;
      x_res_ff   <= x_res_in;
      x_prod_ff  <= x_prod_in;
      out_res_ff <= out_res_in;
      out_ok_ff  <= out_ok_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_vld_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         x_vld_ff   <= x_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

endmodule

`default_nettype wire

// File: design/rv32im_register_alu_unit.sv
// ----------------------------------------------------------------------------
// rv32im_register_alu_unit
// rv32im register-register execute unit with valid/ready channels
// ----------------------------------------------------------------------------
// usage
// - req carries funct3 (command), funct7 (variant) and the two source values;
//   a transaction is taken when req.valid and req.ready are both high
// - rsp returns the destination value and the recognised flag, one
//   transaction per request, in request order
// - alu and multiply results pass through the queue slot, the execute
//   register and the result register
// - divide and remainder run through a radix-2 divider, one quotient bit a
//   cycle: 32 iterations
// - throughput: one transaction per cycle for alu and multiply ops while
//   rsp.ready is high; a divide holds the execute side for 32 iterations,
//   later requests wait in the two-entry queue and then on req.ready
// - the multiplier is a single 33x33 signed array feeding a register
// - reset (synchronous, active high) empties the queue and drops any
//   pending result and divide in flight
// - when rsp.ready stays low the result register holds, the execute
//   register fills, then the queue fills and req.ready falls
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rv32im_register_alu_unit (
   input  wire logic    clock,
   input  wire logic    reset,
   rvalu_req_if.sink    req,
   rvalu_rsp_if.source  rsp
);
   import rvalu_pkg::*;

   // queue head between front and back
   logic              head_vld;
   uop_type           head;
   logic              pop;
   front_status_type  front_status;
   back_status_type   back_status;

   // decode and queue
   rvalu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .pop      (pop),
      .head_vld (head_vld),
      .head     (head),
      .status   (front_status)
   );

   // execute, divide and result register
   rvalu_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_vld (head_vld),
      .head     (head),
      .pop      (pop),
      .rsp      (rsp),
      .status   (back_status)
   );

   `ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp.valid, "rsp valid after reset")
   `ASSERT_RUN(a_queue_bound, clock, reset, front_status.count <= 2'd2, "queue overflow")
   `ASSERT_RUN(a_pop_needs_entry, clock, reset, pop |-> head_vld, "pop from empty queue")
   `ASSERT_RUN(a_div_orders, clock, reset, back_status.div_active |-> !back_status.pop_plain,
      "op passed a divide in flight")

endmodule

`default_nettype wire
